/* rtl/core/lsf_pkg.sv */
// ============================================================================
// lsf_pkg: shared types and constants of the line substring filter
// Holds the descriptor and status structs passed between the front end, the
// descriptor queue and the replay engine, plus register codes and helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

    // Wide enough for a chunk length at the largest supported line capacity.
    localparam int CHUNK_LEN_W = 7;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_IGNORE_CASE    = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One closed, matching chunk waiting for replay.
    typedef struct packed {
        logic                   bank;
        logic [CHUNK_LEN_W-1:0] len;
        logic [31:0]            number;
    } t_chunk_desc;

    // The replay engine is done reading a store bank.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_release;

    typedef struct packed {
        logic active;
        logic bank;
    } t_back_status;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lsf_channels.sv */
// ============================================================================
// lsf_channels: stream interfaces of the line substring filter
// Text byte input channel and replayed line output channel, valid/ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface lsf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface lsf_line_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [31:0] chunk_number;
    logic        end_of_chunk;

    modport source (output valid, output out_byte, output chunk_number,
                    output end_of_chunk, input ready);
    modport sink   (input valid, input out_byte, input chunk_number,
                    input end_of_chunk, output ready);
endinterface

`default_nettype wire

/* rtl/core/lsf_front.sv */
// ============================================================================
// lsf_front: byte intake, chunk splitting and pattern matching
// Writes each accepted byte into the current store bank, keeps the recent
// window and match flag, and queues a descriptor for every matching chunk.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsf_front #(
    parameter int LINE_CAP    = 64,
    parameter int PATTERN_MAX = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    lsf_text_if.sink                           i_text_ch,
    input  wire logic [63:0]                   i_pattern_bytes,
    input  wire logic [3:0]                    i_pattern_length,
    input  wire logic                          i_ignore_case,
    input  wire logic                          i_desc_full,
    input  wire lsf_pkg::t_bank_release        i_release,
    input  wire lsf_pkg::t_back_status         i_back_status,
    output logic                               o_desc_push,
    output lsf_pkg::t_chunk_desc               o_desc,
    output logic                               o_wr_en,
    output logic [$clog2(LINE_CAP):0]          o_wr_addr,
    output logic [7:0]                         o_wr_data
);
    import lsf_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAP);
    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int WIN_W  = 8 * PATTERN_MAX;

    logic [FILL_W-1:0] r_fill;
    logic [WIN_W-1:0]  r_window;
    logic [CNT_W-1:0]  r_wcount;
    logic              r_found;
    logic [31:0]       r_counter;
    logic [1:0]        r_busy;
    logic              r_wbank;

    logic [1:0]        n_busy;
    logic              take;
    logic              close;
    logic              hit;
    logic              found_now;
    logic [FILL_W:0]   new_fill;
    logic [WIN_W-1:0]  new_window;
    logic [CNT_W-1:0]  new_count;
    logic [3:0]        plen;

    assign i_text_ch.ready = !r_busy[r_wbank] && !i_desc_full;
    assign take            = i_text_ch.valid && i_text_ch.ready;

    assign new_fill   = {1'b0, r_fill} + (FILL_W + 1)'(1);
    assign new_window = (r_window << 8) | WIN_W'(i_text_ch.text_byte);
    assign new_count  = (r_wcount == CNT_W'(PATTERN_MAX)) ? r_wcount
                                                          : r_wcount + CNT_W'(1);
    assign plen       = (i_pattern_length > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX)
                                                             : i_pattern_length;

    assign close = (i_text_ch.text_byte == CHAR_NEWLINE)
                || (new_fill >= (FILL_W + 1)'(LINE_CAP - 1))
                || i_text_ch.final_byte;

    // Pattern character i lines up with the window byte that is plen-1-i old.
    always_comb begin
        logic [3:0] age;
        logic [7:0] wb;
        logic [7:0] pb;
        hit = (4'(new_count) >= plen);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            age = plen - 4'd1 - 4'(i);
            wb  = 8'(new_window >> {age, 3'b000});
            pb  = i_pattern_bytes[8*i +: 8];
            if ((4'(i) < plen) && (fold_char(wb, i_ignore_case) !=
                                   fold_char(pb, i_ignore_case))) begin
                hit = 1'b0;
            end
        end
    end

    assign found_now   = r_found || hit;
    assign o_desc_push = take && close && found_now;

    always_comb begin
        o_desc.bank   = r_wbank;
        o_desc.len    = CHUNK_LEN_W'(new_fill);
        o_desc.number = r_counter;
    end

    assign o_wr_en   = take;
    assign o_wr_addr = {r_wbank, r_fill};
    assign o_wr_data = i_text_ch.text_byte;

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_desc_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_window  <= '0;
            r_wcount  <= '0;
            r_found   <= 1'b0;
            r_counter <= 32'd1;
            r_busy    <= '0;
            r_wbank   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (take) begin
                if (close) begin
                    r_fill   <= '0;
                    r_window <= '0;
                    r_wcount <= '0;
                    r_found  <= 1'b0;
                    if (i_text_ch.final_byte) begin
                        r_counter <= 32'd1;
                    end else if (r_counter != 32'hFFFF_FFFF) begin
                        r_counter <= r_counter + 32'd1;
                    end
                    if (found_now) begin
                        r_wbank <= !r_wbank;
                    end
                end else begin
                    r_fill   <= new_fill[FILL_W-1:0];
                    r_window <= new_window;
                    r_wcount <= new_count;
                    r_found  <= found_now;
                end
            end
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_push |-> !i_desc_full)
        else $error("descriptor pushed into a full queue");

    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release.valid |-> r_busy[i_release.bank])
        else $error("replay released a bank that was not in use");

    a_replay_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_back_status.active |-> r_busy[i_back_status.bank])
        else $error("replay reads a bank that the front end may overwrite");

endmodule

`default_nettype wire

/* rtl/core/lsf_desc_fifo.sv */
// ============================================================================
// lsf_desc_fifo: two-entry queue of matching chunk descriptors
// Decouples chunk intake from replay; one entry per store bank.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsf_desc_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire lsf_pkg::t_chunk_desc  i_desc,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output logic                       o_full,
    output lsf_pkg::t_chunk_desc       o_desc
);
    import lsf_pkg::*;

    t_chunk_desc r_entries [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_desc  = r_entries[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lsf_back.sv */
// ============================================================================
// lsf_back: chunk store and replay engine
// Holds two banks of chunk bytes and replays queued chunks one byte per
// cycle while the sink is ready; registered store read data is the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsf_back #(
    parameter int LINE_CAP = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(LINE_CAP):0]   i_wr_addr,
    input  wire logic [7:0]                  i_wr_data,
    input  wire logic                        i_desc_valid,
    input  wire lsf_pkg::t_chunk_desc        i_desc,
    output logic                             o_desc_pop,
    output lsf_pkg::t_bank_release           o_release,
    output lsf_pkg::t_back_status            o_status,
    lsf_line_if.source                       o_line_ch
);
    import lsf_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAP);
    localparam int DEPTH  = 2 << FILL_W;

    logic [7:0]             r_store [DEPTH];

    logic                   r_active;
    logic                   r_bank;
    logic [FILL_W-1:0]      r_idx;
    logic [CHUNK_LEN_W-1:0] r_len;
    logic [31:0]            r_num;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic [31:0]            r_out_num;
    logic                   r_out_end;

    logic                   slot_free;
    logic                   issue;
    logic                   last;

    assign slot_free = !r_out_valid || o_line_ch.ready;
    assign issue     = r_active && slot_free;
    assign last      = ((CHUNK_LEN_W'(r_idx) + CHUNK_LEN_W'(1)) == r_len);

    // A new chunk is taken when idle or right as the current one issues its last byte.
    assign o_desc_pop = i_desc_valid && (!r_active || (issue && last));

    always_comb begin
        o_release.valid = issue && last;
        o_release.bank  = r_bank;
        o_status.active = r_active;
        o_status.bank   = r_bank;
    end

    assign o_line_ch.valid        = r_out_valid;
    assign o_line_ch.out_byte     = r_out_byte;
    assign o_line_ch.chunk_number = r_out_num;
    assign o_line_ch.end_of_chunk = r_out_end;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_byte <= r_store[{r_bank, r_idx}];
            r_out_num  <= r_num;
            r_out_end  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (o_line_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_desc_pop) begin
                r_active <= 1'b1;
            end else if (issue && last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_bank <= i_desc.bank;
            r_idx  <= '0;
            r_len  <= i_desc.len;
            r_num  <= i_desc.number;
        end else if (issue) begin
            r_idx <= r_idx + FILL_W'(1);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/line_substring_filter_core.sv */
// ============================================================================
// line_substring_filter_core: fixed-string line filter
// Splits a byte stream into chunks, matches a configured pattern inside each
// chunk and replays the bytes of every matching chunk with its number.
// ============================================================================
// The block takes one text byte per cycle as long as a store bank is free.
// Chunk bytes go into one of two banks; when a chunk closes on a newline, at
// LINE_CAP-1 bytes or on the final byte, a matching chunk is handed to the
// replay engine and intake continues in the other bank. Replay reads the store
// through its single read port, one byte per cycle while the sink is ready.
// Intake stalls only while both banks hold chunks not yet fully replayed.
// Intake and replay each move one byte per cycle and overlap, so even with
// every line matching and an always-ready sink the sustained rate stays close
// to the intake rate for lines of similar length. A short line that closes
// behind a long matching one waits until the long one has been replayed, and
// a slow sink holds intake to its own pace once both banks are full. The store
// needs no clearing after reset. Configuration is an APB-style port with
// 64-bit registers at byte addresses 0 (pattern bytes), 8 (pattern length)
// and 16 (ignore case).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module line_substring_filter_core #(
    parameter int LINE_CAP    = 64,
    parameter int PATTERN_MAX = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    lsf_text_if.sink                              i_text_ch,
    lsf_line_if.source                            o_line_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lsf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [lsf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [lsf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import lsf_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAP);

    logic [63:0]       r_pattern_bytes;
    logic [3:0]        r_pattern_length;
    logic              r_ignore_case;

    logic              cfg_write;
    logic [1:0]        reg_index;

    logic              desc_push;
    logic              desc_pop;
    logic              desc_valid;
    logic              desc_full;
    t_chunk_desc       desc_in;
    t_chunk_desc       desc_head;
    t_bank_release     release_info;
    t_back_status      back_status;
    logic              wr_en;
    logic [FILL_W:0]   wr_addr;
    logic [7:0]        wr_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
            r_ignore_case    <= 1'b0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_PATTERN_BYTES:  r_pattern_bytes  <= pwdata;
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[3:0];
                REG_IGNORE_CASE:    r_ignore_case    <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_PATTERN_BYTES:  prdata = r_pattern_bytes;
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(r_pattern_length);
            REG_IGNORE_CASE:    prdata = CFG_DATA_W'(r_ignore_case);
            default:            prdata = '0;
        endcase
    end

    lsf_front #(
        .LINE_CAP    (LINE_CAP),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_ch        (i_text_ch),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .i_ignore_case    (r_ignore_case),
        .i_desc_full      (desc_full),
        .i_release        (release_info),
        .i_back_status    (back_status),
        .o_desc_push      (desc_push),
        .o_desc           (desc_in),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data)
    );

    lsf_desc_fifo u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_full  (desc_full),
        .o_desc  (desc_head)
    );

    lsf_back #(
        .LINE_CAP (LINE_CAP)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_desc_valid (desc_valid),
        .i_desc       (desc_head),
        .o_desc_pop   (desc_pop),
        .o_release    (release_info),
        .o_status     (back_status),
        .o_line_ch    (o_line_ch)
    );

endmodule

`default_nettype wire
